>>> src/slwl_pkg.sv
package slwl_pkg;

  // Field widths
  localparam int unsigned TICK_W = 32;
  localparam int unsigned BYTE_W = 8;
  localparam int unsigned CNT_W  = 5;   // counts divide steps 0..TICK_W-1
  localparam int unsigned IDX_W  = 3;   // configuration register index

  // Configuration register indexes
  localparam logic [IDX_W-1:0] CFG_RECORDING  = 3'd0;
  localparam logic [IDX_W-1:0] CFG_PAUSE      = 3'd1;
  localparam logic [IDX_W-1:0] CFG_TPF        = 3'd2;
  localparam logic [IDX_W-1:0] CFG_SKIP_INIT  = 3'd3;
  localparam logic [IDX_W-1:0] CFG_KEYON_INIT = 3'd4;

  // Input opcodes
  localparam logic OP_CPU_RESET  = 1'b0;
  localparam logic OP_PORT_WRITE = 1'b1;

  // Port decode
  localparam logic [BYTE_W-1:0] PORT_BANK_MASK = 8'hFE;
  localparam logic [BYTE_W-1:0] PORT_BANK1     = 8'h46;

  // Key-on detection
  localparam logic [BYTE_W-1:0] REG_FM_KEYON  = 8'h28;
  localparam logic [BYTE_W-1:0] REG_RHY_KEYON = 8'h10;
  localparam logic [BYTE_W-1:0] FM_KEY_MASK   = 8'hF0;
  localparam logic [BYTE_W-1:0] RHY_KEY_MASK  = 8'h1F;
  localparam logic [BYTE_W-1:0] RHY_DUMP_BIT  = 8'h80;

  // Sync codes
  localparam logic [BYTE_W-1:0] SYNC_ONE  = 8'hFF;
  localparam logic [BYTE_W-1:0] SYNC_MANY = 8'hFE;

  // Reset value of ticks_per_frame
  localparam logic [TICK_W-1:0] TPF_RESET = 32'd40000;

  // Divider result as seen by the sequencer
  typedef struct packed {
    logic              done;
    logic [TICK_W-1:0] quot;
    logic [TICK_W-1:0] rem;
  } div_res_t;

endpackage

>>> src/slwl_div.sv
module slwl_div (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  input  logic [slwl_pkg::TICK_W-1:0] dividend,
  input  logic [slwl_pkg::TICK_W-1:0] divisor,
  output slwl_pkg::div_res_t        res
);

  logic                        busy_r, busy_nxt;
  logic                        done_r, done_nxt;
  logic [slwl_pkg::CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [slwl_pkg::TICK_W-1:0] num_r, num_nxt;
  logic [slwl_pkg::TICK_W-1:0] rem_r, rem_nxt;
  logic [slwl_pkg::TICK_W-1:0] den_r, den_nxt;
  logic [slwl_pkg::TICK_W:0]   shifted;
  logic [slwl_pkg::TICK_W+1:0] trial;
  logic                        ge;

  // One restoring step: shift in the next dividend bit, try to subtract
  assign shifted = {rem_r, num_r[slwl_pkg::TICK_W-1]};
  assign trial   = {1'b0, shifted} - {2'b00, den_r};
  assign ge      = ~trial[slwl_pkg::TICK_W+1];

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    num_nxt  = num_r;
    rem_nxt  = rem_r;
    den_nxt  = den_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      num_nxt  = dividend;
      rem_nxt  = '0;
      den_nxt  = divisor;
    end else if (busy_r) begin
      num_nxt = {num_r[slwl_pkg::TICK_W-2:0], ge};
      rem_nxt = ge ? trial[slwl_pkg::TICK_W-1:0] : shifted[slwl_pkg::TICK_W-1:0];
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == slwl_pkg::CNT_W'(slwl_pkg::TICK_W - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  // Datapath
  always_ff @(posedge clk) begin
    num_r <= num_nxt;
    rem_r <= rem_nxt;
    den_r <= den_nxt;
  end

  assign res.done = done_r;
  assign res.quot = num_r;
  assign res.rem  = rem_r;

endmodule

>>> src/sound_register_write_logger_core.sv
// Channel | Dir | Fields (low bit up)
// --------+-----+---------------------------------------------------------------
// in_     | in  | tuser: opcode; tdata: port[7:0], write_data[15:8], tick[47:16]
// out_    | out | tdata: out_byte[7:0]; tlast: last_byte
// cfg_    | in  | we, index[2:0], wdata[31:0]
//
// Events that log nothing (CPU reset, address write, recording off, paused)
// leave the block idle and ready. A logged write is accepted, goes through
// the bit-serial divider, then gives one output byte per cycle while the
// output does not stall (4 to 9), or a sync decision and 3 bytes when no
// frame is due. With ticks_per_frame zero the divider is skipped.
// Output stalls hold the sequencer; the next item is taken while the last
// byte of the previous one still waits. Reset is synchronous, active low.
module sound_register_write_logger_core (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_tvalid,
  output logic                           in_tready,
  input  logic [47:0]                    in_tdata,   // port, write_data, current_tick
  input  logic [0:0]                     in_tuser,   // opcode
  output logic                           out_tvalid,
  input  logic                           out_tready,
  output logic [slwl_pkg::BYTE_W-1:0]    out_tdata,  // out_byte
  output logic                           out_tlast,  // last_byte
  input  logic                           cfg_we,
  input  logic [slwl_pkg::IDX_W-1:0]     cfg_index,
  input  logic [slwl_pkg::TICK_W-1:0]    cfg_wdata
);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_DIV  = 3'd1;
  localparam logic [2:0] ST_SYNC = 3'd2;
  localparam logic [2:0] ST_VAR  = 3'd3;
  localparam logic [2:0] ST_BANK = 3'd4;
  localparam logic [2:0] ST_REG  = 3'd5;
  localparam logic [2:0] ST_VAL  = 3'd6;

  logic [2:0]                  state_r, state_nxt;
  logic                        rec_en_r, rec_en_nxt;
  logic                        pause_r, pause_nxt;
  logic [slwl_pkg::TICK_W-1:0] tpf_r, tpf_nxt;
  logic                        skip_r, skip_nxt;
  logic                        wait_r, wait_nxt;
  logic [slwl_pkg::BYTE_W-1:0] lat0_r, lat0_nxt;
  logic [slwl_pkg::BYTE_W-1:0] lat1_r, lat1_nxt;
  logic [slwl_pkg::TICK_W-1:0] prev_r, prev_nxt;
  logic [slwl_pkg::TICK_W-1:0] left_r, left_nxt;
  logic                        bank_r, bank_nxt;
  logic [slwl_pkg::BYTE_W-1:0] reg_lo_r, reg_lo_nxt;
  logic [slwl_pkg::BYTE_W-1:0] val_r, val_nxt;
  logic [slwl_pkg::TICK_W-1:0] vbits_r, vbits_nxt;
  logic                        oval_r, oval_nxt;
  logic [slwl_pkg::BYTE_W-1:0] odata_r, odata_nxt;
  logic                        olast_r, olast_nxt;

  logic                        accept;
  logic                        out_free;
  logic                        in_op;
  logic [slwl_pkg::BYTE_W-1:0] in_port;
  logic [slwl_pkg::BYTE_W-1:0] in_wdata;
  logic [slwl_pkg::TICK_W-1:0] in_tick;
  logic                        in_bank;
  logic [slwl_pkg::BYTE_W-1:0] cur_reg;
  logic                        keyon;
  logic                        resample;
  logic [slwl_pkg::TICK_W-1:0] elapsed;
  logic [slwl_pkg::TICK_W-1:0] diff;
  logic                        div_start;
  slwl_pkg::div_res_t          div_res;

  // Input unpacking
  assign in_op    = in_tuser[0];
  assign in_port  = in_tdata[7:0];
  assign in_wdata = in_tdata[15:8];
  assign in_tick  = in_tdata[47:16];

  assign in_tready = (state_r == ST_IDLE);
  assign accept    = in_tvalid && in_tready;
  assign out_free  = !oval_r || out_tready;

  // Bank decode and key-on detection (bank 1 registers never match)
  assign in_bank = ((in_port & slwl_pkg::PORT_BANK_MASK) == slwl_pkg::PORT_BANK1);
  assign cur_reg = in_bank ? lat1_r : lat0_r;
  assign keyon = !in_bank && (
      ((cur_reg == slwl_pkg::REG_FM_KEYON) &&
       ((in_wdata & slwl_pkg::FM_KEY_MASK) != '0)) ||
      ((cur_reg == slwl_pkg::REG_RHY_KEYON) &&
       ((in_wdata & slwl_pkg::RHY_DUMP_BIT) == '0) &&
       ((in_wdata & slwl_pkg::RHY_KEY_MASK) != '0)));

  // Elapsed ticks plus carried remainder
  assign resample = skip_r || wait_r;
  assign elapsed  = resample ? '0 : (in_tick - prev_r);
  assign diff     = elapsed + left_r;

  slwl_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (diff),
    .divisor  (tpf_r),
    .res      (div_res)
  );

  always_comb begin
    state_nxt  = state_r;
    rec_en_nxt = rec_en_r;
    pause_nxt  = pause_r;
    tpf_nxt    = tpf_r;
    skip_nxt   = skip_r;
    wait_nxt   = wait_r;
    lat0_nxt   = lat0_r;
    lat1_nxt   = lat1_r;
    prev_nxt   = prev_r;
    left_nxt   = left_r;
    bank_nxt   = bank_r;
    reg_lo_nxt = reg_lo_r;
    val_nxt    = val_r;
    vbits_nxt  = vbits_r;
    oval_nxt   = oval_r;
    odata_nxt  = odata_r;
    olast_nxt  = olast_r;
    div_start  = 1'b0;

    // Output register drains on transfer
    if (oval_r && out_tready) begin
      oval_nxt = 1'b0;
    end

    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          if (in_op == slwl_pkg::OP_CPU_RESET) begin
            prev_nxt = in_tick;
          end else if (!in_port[0]) begin
            if (in_bank) lat1_nxt = in_wdata;
            else         lat0_nxt = in_wdata;
          end else if (rec_en_r) begin
            prev_nxt = in_tick;
            if (!pause_r) begin
              if (wait_r && keyon) wait_nxt = 1'b0;
              if (resample) skip_nxt = 1'b0;
              bank_nxt   = in_bank;
              reg_lo_nxt = cur_reg;
              val_nxt    = in_wdata;
              if (tpf_r == '0) begin
                left_nxt  = diff;
                state_nxt = ST_BANK;
              end else begin
                div_start = 1'b1;
                state_nxt = ST_DIV;
              end
            end
          end
        end
      end
      ST_DIV: begin
        if (div_res.done) begin
          left_nxt  = div_res.rem;
          state_nxt = ST_SYNC;
        end
      end
      ST_SYNC: begin
        if (div_res.quot == '0) begin
          state_nxt = ST_BANK;
        end else if (out_free) begin
          oval_nxt  = 1'b1;
          olast_nxt = 1'b0;
          if (div_res.quot == slwl_pkg::TICK_W'(1)) begin
            odata_nxt = slwl_pkg::SYNC_ONE;
            state_nxt = ST_BANK;
          end else begin
            odata_nxt = slwl_pkg::SYNC_MANY;
            vbits_nxt = div_res.quot - slwl_pkg::TICK_W'(2);
            state_nxt = ST_VAR;
          end
        end
      end
      ST_VAR: begin
        // Seven bits per byte, continuation flag in bit 7
        if (out_free) begin
          oval_nxt  = 1'b1;
          olast_nxt = 1'b0;
          odata_nxt = {(vbits_r[31:7] != '0), vbits_r[6:0]};
          vbits_nxt = {7'd0, vbits_r[31:7]};
          if (vbits_r[31:7] == '0) state_nxt = ST_BANK;
        end
      end
      ST_BANK: begin
        if (out_free) begin
          oval_nxt  = 1'b1;
          olast_nxt = 1'b0;
          odata_nxt = {7'd0, bank_r};
          state_nxt = ST_REG;
        end
      end
      ST_REG: begin
        if (out_free) begin
          oval_nxt  = 1'b1;
          olast_nxt = 1'b0;
          odata_nxt = reg_lo_r;
          state_nxt = ST_VAL;
        end
      end
      ST_VAL: begin
        if (out_free) begin
          oval_nxt  = 1'b1;
          olast_nxt = 1'b1;
          odata_nxt = val_r;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    // Configuration writes
    if (cfg_we) begin
      case (cfg_index)
        slwl_pkg::CFG_RECORDING:  rec_en_nxt = cfg_wdata[0];
        slwl_pkg::CFG_PAUSE:      pause_nxt  = cfg_wdata[0];
        slwl_pkg::CFG_TPF:        tpf_nxt    = cfg_wdata;
        slwl_pkg::CFG_SKIP_INIT:  skip_nxt   = cfg_wdata[0];
        slwl_pkg::CFG_KEYON_INIT: wait_nxt   = cfg_wdata[0];
        default: ;
      endcase
    end
  end

  // Control and architectural state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      rec_en_r <= 1'b0;
      pause_r  <= 1'b0;
      tpf_r    <= slwl_pkg::TPF_RESET;
      skip_r   <= 1'b1;
      wait_r   <= 1'b1;
      lat0_r   <= '0;
      lat1_r   <= '0;
      prev_r   <= '0;
      left_r   <= '0;
      oval_r   <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      rec_en_r <= rec_en_nxt;
      pause_r  <= pause_nxt;
      tpf_r    <= tpf_nxt;
      skip_r   <= skip_nxt;
      wait_r   <= wait_nxt;
      lat0_r   <= lat0_nxt;
      lat1_r   <= lat1_nxt;
      prev_r   <= prev_nxt;
      left_r   <= left_nxt;
      oval_r   <= oval_nxt;
    end
  end

  // Payload
  always_ff @(posedge clk) begin
    bank_r   <= bank_nxt;
    reg_lo_r <= reg_lo_nxt;
    val_r    <= val_nxt;
    vbits_r  <= vbits_nxt;
    odata_r  <= odata_nxt;
    olast_r  <= olast_nxt;
  end

  assign out_tvalid = oval_r;
  assign out_tdata  = odata_r;
  assign out_tlast  = olast_r;

endmodule

>>> src/slwl_checker.sv
module slwl_checker (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        in_tvalid,
  input logic                        in_tready,
  input logic [47:0]                 in_tdata,
  input logic [0:0]                  in_tuser,
  input logic                        out_tvalid,
  input logic                        out_tready,
  input logic [slwl_pkg::BYTE_W-1:0] out_tdata,
  input logic                        out_tlast
);

  // A stalled result byte holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready) |=> (out_tvalid && $stable(out_tdata) && $stable(out_tlast)))
    else $error("stalled result byte changed");

  // No new item while a record is still being emitted
  a_busy_mid_record: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tlast) |-> !in_tready)
    else $error("input ready in the middle of a record");

  // CPU reset events and address writes leave the input ready in the next cycle
  a_quick_items: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready &&
     ((in_tuser[0] == slwl_pkg::OP_CPU_RESET) || !in_tdata[0])) |=> in_tready)
    else $error("non-logging item kept the block busy");

  // Output is empty right after reset
  a_reset_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !$past(rst_n) |-> (!out_tvalid && in_tready))
    else $error("block not empty after reset");

endmodule

bind sound_register_write_logger_core slwl_checker u_slwl_checker (.*);

>>> tb/sound_register_write_logger_core_test.sv
`timescale 1ns / 100ps

module sound_register_write_logger_core_test;

  localparam int unsigned GAP_PCT   = 16;
  localparam int unsigned HOLD_LEN  = 400;
  localparam int unsigned DRAIN_LEN = 60;
  localparam int unsigned CYCLE_CAP = 300000;
  localparam int unsigned PHASE_LEN = 14;

  // Sound chip ports: even latches the register, odd writes data
  localparam logic [slwl_pkg::BYTE_W-1:0] PORT_B0_ADDR = 8'h44;
  localparam logic [slwl_pkg::BYTE_W-1:0] PORT_B0_DATA = 8'h45;
  localparam logic [slwl_pkg::BYTE_W-1:0] PORT_B1_ADDR = 8'h46;
  localparam logic [slwl_pkg::BYTE_W-1:0] PORT_B1_DATA = 8'h47;

  typedef struct {
    logic                        op;
    logic [slwl_pkg::BYTE_W-1:0] port;
    logic [slwl_pkg::BYTE_W-1:0] data;
    logic [slwl_pkg::TICK_W-1:0] tick;
  } chip_event_t;

  typedef struct {
    logic [slwl_pkg::BYTE_W-1:0] value;
    logic                        last;
  } log_byte_t;

  logic                          clk = 1'b0;
  logic                          rst_n = 1'b0;
  logic                          in_tvalid = 1'b0;
  logic                          in_tready;
  logic [47:0]                   in_tdata = '0;   // port, write_data, current_tick
  logic [0:0]                    in_tuser = '0;   // opcode
  logic                          out_tvalid;
  logic                          out_tready = 1'b0;
  logic [slwl_pkg::BYTE_W-1:0]   out_tdata;       // out_byte
  logic                          out_tlast;       // last_byte
  logic                          cfg_we = 1'b0;
  logic [slwl_pkg::IDX_W-1:0]    cfg_index = '0;
  logic [slwl_pkg::TICK_W-1:0]   cfg_wdata = '0;

  // Stimulus and expected log stream
  chip_event_t pending_events[$];
  chip_event_t cur_event;
  log_byte_t   exp_log[$];
  logic [slwl_pkg::TICK_W-1:0] tb_tick = '0;
  int unsigned gap_pct = GAP_PCT;
  int          hold_reqs = 0;
  int          hold_served = 0;
  int          hold_left = 0;
  int          mismatches = 0;
  int unsigned cycle_count = 0;
  int unsigned events_made = 0;

  // Logger state as predicted by the testbench
  logic                        rec_on;
  logic                        paused;
  logic [slwl_pkg::TICK_W-1:0] frame_ticks;
  logic [slwl_pkg::BYTE_W-1:0] bank_reg [2];
  logic [slwl_pkg::TICK_W-1:0] last_tick;
  logic [slwl_pkg::TICK_W-1:0] carry_ticks;
  logic [slwl_pkg::TICK_W-1:0] owed_frames;
  logic                        skip_sync;
  logic                        await_keyon;

  sound_register_write_logger_core u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic void push_log_byte(input logic [slwl_pkg::BYTE_W-1:0] v,
                                        input logic last);
    log_byte_t lb;
    lb.value = v;
    lb.last  = last;
    exp_log.push_back(lb);
  endfunction

  // Expected log bytes for one accepted chip event
  function automatic void predict_log_bytes(input chip_event_t ev);
    logic                        bank;
    logic [8:0]                  reg_addr;
    logic [slwl_pkg::TICK_W-1:0] span;
    logic [slwl_pkg::TICK_W-1:0] frames;
    logic [slwl_pkg::TICK_W-1:0] rest;
    logic [6:0]                  seven;
    logic                        resample;
    if (ev.op == slwl_pkg::OP_CPU_RESET) begin
      last_tick = ev.tick;
      return;
    end
    bank = ((ev.port & slwl_pkg::PORT_BANK_MASK) == slwl_pkg::PORT_BANK1);
    if (!ev.port[0]) begin
      bank_reg[bank] = ev.data;
      return;
    end
    reg_addr = {bank, bank_reg[bank]};
    if (!rec_on)
      return;
    if (paused) begin
      last_tick = ev.tick;
      return;
    end
    // key-on wait and first-sync skip both zero the elapsed time
    resample = skip_sync;
    if (await_keyon) begin
      resample = 1'b1;
      if (reg_addr == {1'b0, slwl_pkg::REG_FM_KEYON} &&
          (ev.data & slwl_pkg::FM_KEY_MASK) != 0)
        await_keyon = 1'b0;
      if (reg_addr == {1'b0, slwl_pkg::REG_RHY_KEYON} &&
          (ev.data & slwl_pkg::RHY_DUMP_BIT) == 0 &&
          (ev.data & slwl_pkg::RHY_KEY_MASK) != 0)
        await_keyon = 1'b0;
    end
    if (resample) begin
      last_tick = ev.tick;
      skip_sync = 1'b0;
    end
    span        = ev.tick - last_tick + carry_ticks;
    last_tick   = ev.tick;
    frames      = (frame_ticks != 0) ? span / frame_ticks : '0;
    carry_ticks = span - frames * frame_ticks;
    owed_frames = owed_frames + frames;
    // sync: single frame code, or multi-frame code plus varint of n-2
    if (owed_frames == 1) begin
      push_log_byte(slwl_pkg::SYNC_ONE, 1'b0);
    end else if (owed_frames != 0) begin
      rest = owed_frames - 2;
      push_log_byte(slwl_pkg::SYNC_MANY, 1'b0);
      do begin
        seven = rest[6:0];
        rest  = rest >> 7;
        push_log_byte({rest != 0, seven}, 1'b0);
      end while (rest != 0);
    end
    owed_frames = '0;
    push_log_byte({7'd0, bank}, 1'b0);
    push_log_byte(reg_addr[7:0], 1'b0);
    push_log_byte(ev.data, 1'b1);
  endfunction

  task automatic report_mismatch(input string what);
    $display("[%0t] mismatch: %s", $time, what);
    mismatches++;
  endtask

  // Register write while the logger is idle; prediction follows at once
  task automatic write_reg(input logic [slwl_pkg::IDX_W-1:0] idx,
                           input logic [slwl_pkg::TICK_W-1:0] val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    case (idx)
      slwl_pkg::CFG_RECORDING:  rec_on = val[0];
      slwl_pkg::CFG_PAUSE:      paused = val[0];
      slwl_pkg::CFG_TPF:        frame_ticks = val;
      slwl_pkg::CFG_SKIP_INIT:  skip_sync = val[0];
      slwl_pkg::CFG_KEYON_INIT: await_keyon = val[0];
      default: ;
    endcase
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic add_event(input logic op, input logic [slwl_pkg::BYTE_W-1:0] port,
                           input logic [slwl_pkg::BYTE_W-1:0] data,
                           input logic [slwl_pkg::TICK_W-1:0] tick);
    chip_event_t ev;
    ev.op   = op;
    ev.port = port;
    ev.data = data;
    ev.tick = tick;
    tb_tick = tick;
    events_made++;
    pending_events.push_back(ev);
  endtask

  // Tick steps scaled to the frame length, with the odd jump or repeat
  function automatic logic [slwl_pkg::TICK_W-1:0] next_tick();
    longint unsigned reach;
    reach = (frame_ticks == 0) ? 64'd5000 : 64'(frame_ticks) * 3;
    case ($urandom_range(9))
      0: return $urandom();
      1: return tb_tick;
      default: return tb_tick + ((reach > 64'hFFFF_FFFF) ? $urandom()
                                                        : $urandom_range(0, 32'(reach)));
    endcase
  endfunction

  // Mostly address-then-data pairs, some bare data writes, CPU resets and noise
  task automatic add_random_seq();
    logic [slwl_pkg::BYTE_W-1:0] a_port;
    logic [slwl_pkg::BYTE_W-1:0] reg_pick;
    int                          pick;
    pick   = $urandom_range(99);
    a_port = $urandom_range(1) ? PORT_B1_ADDR : PORT_B0_ADDR;
    if (pick < 65) begin
      case ($urandom_range(3))
        0: reg_pick = slwl_pkg::REG_FM_KEYON;
        1: reg_pick = slwl_pkg::REG_RHY_KEYON;
        default: reg_pick = 8'($urandom());
      endcase
      add_event(slwl_pkg::OP_PORT_WRITE, a_port, reg_pick, tb_tick);
      add_event(slwl_pkg::OP_PORT_WRITE, a_port | 8'h01, 8'($urandom()), next_tick());
    end else if (pick < 80) begin
      add_event(slwl_pkg::OP_PORT_WRITE, a_port | 8'h01, 8'($urandom()), next_tick());
    end else if (pick < 90) begin
      add_event(slwl_pkg::OP_CPU_RESET, 8'($urandom()), 8'($urandom()), next_tick());
    end else begin
      add_event(slwl_pkg::OP_PORT_WRITE, 8'($urandom()), 8'($urandom()), next_tick());
    end
  endtask

  // Everything sent and every byte back, then a drain pause
  task automatic wait_quiet();
    while (pending_events.size() != 0 || in_tvalid || exp_log.size() != 0)
      @(posedge clk);
    repeat (DRAIN_LEN) @(posedge clk);
  endtask

  // Input driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready)
        predict_log_bytes(cur_event);
      if (!in_tvalid || in_tready) begin
        if (pending_events.size() != 0 && $urandom_range(99) >= gap_pct) begin
          cur_event = pending_events.pop_front();
          in_tvalid <= 1'b1;
          in_tuser  <= cur_event.op;
          in_tdata  <= {cur_event.tick, cur_event.data, cur_event.port};
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // Output ready: random stalls, plus a long hold-off on request
  always @(posedge clk) begin
    if (hold_served != hold_reqs) begin
      hold_served <= hold_reqs;
      hold_left   <= HOLD_LEN;
      out_tready  <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left  <= hold_left - 1;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(99) >= gap_pct);
    end
  end

  // Output monitor: each transfer against the oldest expected byte
  always @(posedge clk) begin : mon
    log_byte_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (exp_log.size() == 0) begin
        report_mismatch($sformatf("unexpected byte %02h last %0b", out_tdata, out_tlast));
      end else begin
        want = exp_log.pop_front();
        if (out_tdata !== want.value)
          report_mismatch($sformatf("byte %02h, expected %02h", out_tdata, want.value));
        if (out_tlast !== want.last)
          report_mismatch($sformatf("last %0b, expected %0b on byte %02h",
                                    out_tlast, want.last, want.value));
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_CAP) begin
      $display("[sound_register_write_logger_core] ERROR");
      $finish;
    end
  end

  initial begin : stim
    int unsigned phase_end;
    logic [slwl_pkg::TICK_W-1:0] tpf_pick;
    // predicted state after reset
    rec_on      = 1'b0;
    paused      = 1'b0;
    frame_ticks = slwl_pkg::TPF_RESET;
    bank_reg[0] = '0;
    bank_reg[1] = '0;
    last_tick   = '0;
    carry_ticks = '0;
    owed_frames = '0;
    skip_sync   = 1'b1;
    await_keyon = 1'b1;

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // recording off: data ignored, address still latched
    add_event(slwl_pkg::OP_PORT_WRITE, PORT_B0_DATA, 8'h5A, 32'd10);
    add_event(slwl_pkg::OP_CPU_RESET, 8'hFF, 8'hFF, 32'd200);
    add_event(slwl_pkg::OP_PORT_WRITE, PORT_B0_ADDR, slwl_pkg::REG_RHY_KEYON, 32'd0);
    wait_quiet();

    // key-on wait, sync codes, varint, tick wrap
    write_reg(slwl_pkg::CFG_RECORDING, 32'd1);
    write_reg(slwl_pkg::CFG_TPF, 32'd100);
    add_event(slwl_pkg::OP_PORT_WRITE, PORT_B0_DATA, 8'h9F, 32'd1000);   // dump bit: no key-on
    add_event(slwl_pkg::OP_PORT_WRITE, PORT_B0_DATA, 8'h00, 32'd5000);
    add_event(slwl_pkg::OP_PORT_WRITE, PORT_B1_ADDR, slwl_pkg::REG_RHY_KEYON, 32'd5000);
    add_event(slwl_pkg::OP_PORT_WRITE, PORT_B1_DATA, 8'h1F, 32'd6000);   // bank 1: no key-on
    add_event(slwl_pkg::OP_PORT_WRITE, PORT_B0_ADDR, slwl_pkg::REG_FM_KEYON, 32'd6000);
    add_event(slwl_pkg::OP_PORT_WRITE, PORT_B0_DATA, 8'h0F, 32'd7000);
    add_event(slwl_pkg::OP_PORT_WRITE, PORT_B0_DATA, 8'hF1, 32'd8000);   // FM key-on
    add_event(slwl_pkg::OP_PORT_WRITE, PORT_B0_DATA, 8'hFF, 32'd8100);   // one frame
    add_event(slwl_pkg::OP_PORT_WRITE, PORT_B0_DATA, 8'h33, 32'd8100);   // no frame
    add_event(slwl_pkg::OP_PORT_WRITE, PORT_B0_DATA, 8'h44, 32'd8350);   // two frames
    add_event(slwl_pkg::OP_PORT_WRITE, PORT_B0_DATA, 8'h55, 32'd21400);  // two-byte varint
    add_event(slwl_pkg::OP_CPU_RESET, 8'h00, 8'h00, 32'hFFFF_FF00);
    add_event(slwl_pkg::OP_PORT_WRITE, PORT_B0_DATA, 8'h66, 32'h0000_0100);
    add_event(slwl_pkg::OP_PORT_WRITE, 8'h00, 8'h00, 32'h0000_0000);
    add_event(slwl_pkg::OP_PORT_WRITE, 8'hFF, 8'hFF, 32'hFFFF_FFFF);
    wait_quiet();

    // pause resamples only
    write_reg(slwl_pkg::CFG_PAUSE, 32'd1);
    add_event(slwl_pkg::OP_PORT_WRITE, PORT_B1_DATA, 8'hA5, 32'h1234_5678);
    wait_quiet();
    write_reg(slwl_pkg::CFG_PAUSE, 32'd0);

    // zero frame length accumulates, then a one-tick frame gives the longest sync
    write_reg(slwl_pkg::CFG_TPF, 32'd0);
    add_event(slwl_pkg::OP_PORT_WRITE, PORT_B0_DATA, 8'h01, tb_tick + 32'h7000_0000);
    add_event(slwl_pkg::OP_PORT_WRITE, PORT_B0_DATA, 8'h02, tb_tick + 32'h7000_0000);
    wait_quiet();
    write_reg(slwl_pkg::CFG_TPF, 32'd1);
    add_event(slwl_pkg::OP_PORT_WRITE, PORT_B0_DATA, 8'h03, tb_tick + 32'h1FFF_FFF0);
    wait_quiet();

    // longest frame, skip flag reload, rhythm key-on
    write_reg(slwl_pkg::CFG_TPF, 32'hFFFF_FFFF);
    write_reg(slwl_pkg::CFG_SKIP_INIT, 32'd1);
    write_reg(slwl_pkg::CFG_KEYON_INIT, 32'd1);
    add_event(slwl_pkg::OP_PORT_WRITE, PORT_B0_ADDR, slwl_pkg::REG_RHY_KEYON, tb_tick);
    add_event(slwl_pkg::OP_PORT_WRITE, PORT_B0_DATA, 8'h01, tb_tick + 32'h0000_0500);
    add_event(slwl_pkg::OP_PORT_WRITE, PORT_B0_DATA, 8'h7E, tb_tick + 32'hFFFF_FFFE);
    add_event(slwl_pkg::OP_PORT_WRITE, PORT_B0_DATA, 8'h80, tb_tick + 32'd5);
    wait_quiet();

    // random phases across frame lengths and flag settings
    for (int p = 0; p < 6; p++) begin
      case (p)
        0: tpf_pick = 32'd1;
        1: tpf_pick = $urandom_range(2, 1000);
        2: tpf_pick = 32'd0;
        3: tpf_pick = slwl_pkg::TPF_RESET;
        4: tpf_pick = 32'hFFFF_FFFF;
        default: tpf_pick = $urandom_range(50, 5000);
      endcase
      write_reg(slwl_pkg::CFG_TPF, tpf_pick);
      write_reg(slwl_pkg::CFG_SKIP_INIT, $urandom_range(1));
      write_reg(slwl_pkg::CFG_KEYON_INIT, 32'($urandom_range(3) == 0));
      write_reg(slwl_pkg::CFG_RECORDING, (p < 3) ? 32'd1 : 32'($urandom_range(7) != 0));
      write_reg(slwl_pkg::CFG_PAUSE, (p < 3) ? 32'd0 : 32'($urandom_range(7) == 0));
      gap_pct = (p == 0) ? 0 : GAP_PCT;
      // receiver holds off while the sender keeps offering
      if (p == 1)
        hold_reqs = hold_reqs + 1;
      phase_end = events_made + PHASE_LEN;
      while (events_made < phase_end)
        add_random_seq();
      wait_quiet();
    end

    if (mismatches == 0 && exp_log.size() == 0)
      $display("[sound_register_write_logger_core] OK");
    else
      $display("[sound_register_write_logger_core] ERROR");
    $finish;
  end

endmodule
